[rtl/ffca_pkg.sv]
`timescale 1ns / 1ps

package ffca_pkg;

    localparam int GRID_WIDTH  = 256;
    localparam int GRID_HEIGHT = 256;
    localparam int FIRE_SLOTS  = 2048;
    localparam int NUM_BINS    = 24;

    localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
    localparam int CELL_W      = $clog2(CELL_COUNT);
    localparam int X_W         = $clog2(GRID_WIDTH);
    localparam int Y_W         = $clog2(GRID_HEIGHT);
    localparam int SLOT_W      = $clog2(FIRE_SLOTS);
    localparam int BIN_W       = $clog2(NUM_BINS);

    // slot entry: {active, generation stamp, size}
    localparam int SLOT_ENTRY_W = 34;
    localparam int SE_ACTIVE    = 33;
    localparam int SE_STAMP     = 32;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 144;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_TREE  = 2'd1;
    localparam logic [1:0] ST_FIRE  = 2'd2;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_STEP = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic CFG_GROW   = 1'b0;
    localparam logic CFG_STRIKE = 1'b1;

    localparam logic [31:0] GROW_THR_RESET   = 32'd85899346;
    localparam logic [31:0] STRIKE_THR_RESET = 32'd85899;
    localparam logic [16:0] TALLY_MAX        = 17'h1FFFF;
    localparam logic [31:0] U32_MAX          = 32'hFFFFFFFF;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CTR,
        S_NB,
        S_MAP,
        S_SLOT,
        S_CLAIM,
        S_WB,
        S_SWEEP,
        S_OUT
    } state_t;

endpackage

[rtl/forest_fire_ca_step.sv]
`timescale 1ns / 1ps

// Forest-fire automaton stepper on a GRID_WIDTH x GRID_HEIGHT torus. Each
// transaction on the s side loads a cell (mode 0), advances the next cell in
// raster order (mode 1), reads a fire-size histogram bin (mode 2) or does
// nothing (mode 3), and yields exactly one result transaction on the m side;
// m_tlast marks the last cell of a generation, which also carries the
// generation totals. Grid, fire map and slot table live in single-read-port
// synchronous RAMs, so a step does its reads in sequence: the cell itself,
// then for a tree its neighbors in turn until one burns, then that fire's
// map entry and slot entry; a lightning strike instead probes the slot
// table for a free fire slot (up to FIRE_SLOTS probes). The last cell of a
// generation adds a sweep over the slot table. Load, read and unused-mode
// transactions are answered directly from the idle state. After reset the
// block clears grid_a and the slot table before accepting any transaction;
// configuration writes are taken at any time.

module forest_fire_ca_step
    import ffca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] cell_index, [16] cell_value, [48:17] rand_grow,
    // [80:49] rand_strike, [85:81] bin_index, [87:86] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  logic [1:0]            s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] new_state, [12:2] fire_slot, [13] strike_dropped,
    // [30:14] tree_count, [47:31] burning_count, [79:48] fires_total,
    // [111:80] largest_fire, [143:112] bin_count
    output logic [OUT_DATA_W-1:0] m_tdata,
    // generation_done
    output logic                  m_tlast
);

    // input fields
    logic [15:0] in_cidx;
    logic        in_cval;
    logic [31:0] in_rgrow;
    logic [31:0] in_rstrike;
    logic [4:0]  in_bidx;
    assign in_cidx    = s_tdata[15:0];
    assign in_cval    = s_tdata[16];
    assign in_rgrow   = s_tdata[48:17];
    assign in_rstrike = s_tdata[80:49];
    assign in_bidx    = s_tdata[85:81];

    state_t state_reg, state_next;

    logic [31:0] grow_thr_reg, strike_thr_reg;

    logic              bsel_reg, bsel_next;   // 1: grid_b is current
    logic              gen_reg, gen_next;     // generation parity for slot stamps
    logic [SLOT_W-1:0] next_slot_reg, next_slot_next;
    logic [X_W-1:0]    scan_x_reg, scan_x_next;
    logic [Y_W-1:0]    scan_y_reg, scan_y_next;
    logic [16:0]       tree_tally_reg, tree_tally_next;
    logic [16:0]       burn_tally_reg, burn_tally_next;
    logic [31:0]       closed_reg, closed_next;
    logic [31:0]       biggest_reg, biggest_next;
    logic [31:0]       hist_reg [NUM_BINS];
    logic              hist_we;
    logic [BIN_W-1:0]  hist_bin;

    logic [CELL_W-1:0] clr_cnt_reg, clr_cnt_next;

    // per-item work registers (payload, no reset)
    logic [31:0]       rgrow_reg, rgrow_next;
    logic [31:0]       rstrike_reg, rstrike_next;
    logic [1:0]        k_reg, k_next;
    logic [1:0]        ns_reg, ns_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              burning_reg, burning_next;
    logic              dropped_reg, dropped_next;
    logic              done_reg, done_next;
    logic [SLOT_W-1:0] probe_reg, probe_next;
    logic [SLOT_W-1:0] probe_cnt_reg, probe_cnt_next;
    logic [SLOT_W-1:0] sweep_reg, sweep_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_free;

    // memory ports
    logic                    ga_we, gb_we;
    logic [CELL_W-1:0]       g_waddr, g_raddr;
    logic [1:0]              g_wdata, ga_rdata, gb_rdata, cur_rdata;
    logic                    map_we;
    logic [CELL_W-1:0]       map_raddr;
    logic [SLOT_W-1:0]       map_rdata;
    logic                    sl_we;
    logic [SLOT_W-1:0]       sl_waddr, sl_raddr;
    logic [SLOT_ENTRY_W-1:0] sl_wdata, sl_rdata;

    function automatic logic [CELL_W-1:0] cell_addr(input logic [Y_W-1:0] y,
                                                    input logic [X_W-1:0] x);
        cell_addr = CELL_W'(int'(y) * GRID_WIDTH + int'(x));
    endfunction

    function automatic logic [16:0] sat_inc17(input logic [16:0] v);
        sat_inc17 = (v == TALLY_MAX) ? v : v + 17'd1;
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (v == U32_MAX) ? v : v + 32'd1;
    endfunction

    function automatic logic [BIN_W-1:0] size_bin(input logic [31:0] v);
        logic [5:0] r;
        r = 6'd0;
        for (int b = 1; b < 32; b++)
        begin
            if (v[b])
            begin
                r = 6'(b);
            end
        end
        if (int'(r) >= NUM_BINS)
        begin
            r = 6'(NUM_BINS - 1);
        end
        size_bin = r[BIN_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (int'(s) == FIRE_SLOTS - 1) ? '0 : s + SLOT_W'(1);
    endfunction

    // torus neighbours of the scan position
    logic [X_W-1:0]    xl, xr;
    logic [Y_W-1:0]    yu, yd;
    logic [CELL_W-1:0] center_addr;
    logic [CELL_W-1:0] nb_addr [4];
    logic              last_cell;

    assign xl = (scan_x_reg == '0) ? X_W'(GRID_WIDTH - 1) : scan_x_reg - X_W'(1);
    assign xr = (int'(scan_x_reg) == GRID_WIDTH - 1) ? '0 : scan_x_reg + X_W'(1);
    assign yu = (scan_y_reg == '0) ? Y_W'(GRID_HEIGHT - 1) : scan_y_reg - Y_W'(1);
    assign yd = (int'(scan_y_reg) == GRID_HEIGHT - 1) ? '0 : scan_y_reg + Y_W'(1);
    assign center_addr = cell_addr(scan_y_reg, scan_x_reg);
    assign nb_addr[0]  = cell_addr(scan_y_reg, xl);
    assign nb_addr[1]  = cell_addr(scan_y_reg, xr);
    assign nb_addr[2]  = cell_addr(yu, scan_x_reg);
    assign nb_addr[3]  = cell_addr(yd, scan_x_reg);
    assign last_cell   = (int'(scan_x_reg) == GRID_WIDTH - 1) &&
                         (int'(scan_y_reg) == GRID_HEIGHT - 1);

    assign cur_rdata = bsel_reg ? gb_rdata : ga_rdata;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;

    ffca_ram #(.WIDTH(2), .DEPTH(CELL_COUNT)) u_grid_a (
        .clk(clk), .we(ga_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(ga_rdata)
    );

    ffca_ram #(.WIDTH(2), .DEPTH(CELL_COUNT)) u_grid_b (
        .clk(clk), .we(gb_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(gb_rdata)
    );

    ffca_ram #(.WIDTH(SLOT_W), .DEPTH(CELL_COUNT)) u_fire_map (
        .clk(clk), .we(map_we), .waddr(center_addr), .wdata(slot_reg),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    ffca_ram #(.WIDTH(SLOT_ENTRY_W), .DEPTH(FIRE_SLOTS)) u_slots (
        .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
        .raddr(sl_raddr), .rdata(sl_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grow_thr_reg   <= GROW_THR_RESET;
            strike_thr_reg <= STRIKE_THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GROW:   grow_thr_reg   <= cfg_data;
                CFG_STRIKE: strike_thr_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        bsel_next       = bsel_reg;
        gen_next        = gen_reg;
        next_slot_next  = next_slot_reg;
        scan_x_next     = scan_x_reg;
        scan_y_next     = scan_y_reg;
        tree_tally_next = tree_tally_reg;
        burn_tally_next = burn_tally_reg;
        closed_next     = closed_reg;
        biggest_next    = biggest_reg;
        clr_cnt_next    = clr_cnt_reg;
        rgrow_next      = rgrow_reg;
        rstrike_next    = rstrike_reg;
        k_next          = k_reg;
        ns_next         = ns_reg;
        slot_next       = slot_reg;
        burning_next    = burning_reg;
        dropped_next    = dropped_reg;
        done_next       = done_reg;
        probe_next      = probe_reg;
        probe_cnt_next  = probe_cnt_reg;
        sweep_next      = sweep_reg;

        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        hist_we  = 1'b0;
        hist_bin = size_bin(sl_rdata[31:0]);

        ga_we     = 1'b0;
        gb_we     = 1'b0;
        g_waddr   = center_addr;
        g_wdata   = ns_reg;
        g_raddr   = center_addr;
        map_we    = 1'b0;
        map_raddr = nb_addr[k_reg];
        sl_we     = 1'b0;
        sl_waddr  = sweep_reg;
        sl_wdata  = sl_rdata;
        sl_raddr  = slot_inc(sweep_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                ga_we    = 1'b1;
                g_waddr  = clr_cnt_reg;
                g_wdata  = ST_EMPTY;
                sl_we    = (int'(clr_cnt_reg) < FIRE_SLOTS);
                sl_waddr = SLOT_W'(clr_cnt_reg);
                sl_wdata = '0;
                clr_cnt_next = clr_cnt_reg + CELL_W'(1);
                if (int'(clr_cnt_reg) == CELL_COUNT - 1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    out_data_next = '0;
                    out_last_next = 1'b0;
                    unique case (s_tuser)
                        MODE_LOAD:
                        begin
                            g_waddr = in_cidx[CELL_W-1:0];
                            g_wdata = {1'b0, in_cval};
                            if (int'(in_cidx) < CELL_COUNT)
                            begin
                                ga_we = !bsel_reg;
                                gb_we = bsel_reg;
                            end
                            out_valid_next = 1'b1;
                        end
                        MODE_READ:
                        begin
                            if (int'(in_bidx) < NUM_BINS)
                            begin
                                out_data_next[143:112] = hist_reg[in_bidx[BIN_W-1:0]];
                            end
                            out_valid_next = 1'b1;
                        end
                        MODE_STEP:
                        begin
                            rgrow_next   = in_rgrow;
                            rstrike_next = in_rstrike;
                            burning_next = 1'b0;
                            dropped_next = 1'b0;
                            done_next    = 1'b0;
                            slot_next    = '0;
                            if (scan_x_reg == '0 && scan_y_reg == '0)
                            begin
                                tree_tally_next = '0;
                                burn_tally_next = '0;
                            end
                            g_raddr    = center_addr;
                            state_next = S_CTR;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            S_CTR:
            begin
                if (cur_rdata == ST_FIRE)
                begin
                    ns_next    = ST_EMPTY;
                    state_next = S_WB;
                end
                else if (cur_rdata == ST_TREE)
                begin
                    k_next     = 2'd0;
                    g_raddr    = nb_addr[0];
                    state_next = S_NB;
                end
                else
                begin
                    // empty, and the code that cannot arise, grow alike
                    ns_next    = (rgrow_reg < grow_thr_reg) ? ST_TREE : ST_EMPTY;
                    state_next = S_WB;
                end
            end

            S_NB:
            begin
                if (cur_rdata == ST_FIRE)
                begin
                    map_raddr  = nb_addr[k_reg];
                    state_next = S_MAP;
                end
                else if (k_reg != 2'd3)
                begin
                    k_next  = k_reg + 2'd1;
                    g_raddr = nb_addr[k_reg + 2'd1];
                end
                else if (rstrike_reg < strike_thr_reg)
                begin
                    sl_raddr       = next_slot_reg;
                    probe_next     = next_slot_reg;
                    probe_cnt_next = '0;
                    state_next     = S_CLAIM;
                end
                else
                begin
                    ns_next    = ST_TREE;
                    state_next = S_WB;
                end
            end

            S_MAP:
            begin
                slot_next  = map_rdata;
                sl_raddr   = map_rdata;
                state_next = S_SLOT;
            end

            S_SLOT:
            begin
                sl_we    = 1'b1;
                sl_waddr = slot_reg;
                sl_wdata = {sl_rdata[SE_ACTIVE], gen_reg, sat_inc32(sl_rdata[31:0])};
                burning_next = 1'b1;
                ns_next      = ST_FIRE;
                state_next   = S_WB;
            end

            S_CLAIM:
            begin
                sl_raddr = slot_inc(probe_reg);
                if (!sl_rdata[SE_ACTIVE])
                begin
                    sl_we    = 1'b1;
                    sl_waddr = probe_reg;
                    sl_wdata = {1'b1, gen_reg, 32'd1};
                    slot_next      = probe_reg;
                    next_slot_next = slot_inc(probe_reg);
                    burning_next   = 1'b1;
                    ns_next        = ST_FIRE;
                    state_next     = S_WB;
                end
                else if (int'(probe_cnt_reg) == FIRE_SLOTS - 1)
                begin
                    dropped_next = 1'b1;
                    ns_next      = ST_TREE;
                    state_next   = S_WB;
                end
                else
                begin
                    probe_next     = slot_inc(probe_reg);
                    probe_cnt_next = probe_cnt_reg + SLOT_W'(1);
                end
            end

            S_WB:
            begin
                // next generation goes to the other buffer
                g_waddr = center_addr;
                g_wdata = ns_reg;
                ga_we   = bsel_reg;
                gb_we   = !bsel_reg;
                map_we  = burning_reg;
                if (ns_reg == ST_TREE)
                begin
                    tree_tally_next = sat_inc17(tree_tally_reg);
                end
                if (ns_reg == ST_FIRE)
                begin
                    burn_tally_next = sat_inc17(burn_tally_reg);
                end
                if (int'(scan_x_reg) == GRID_WIDTH - 1)
                begin
                    scan_x_next = '0;
                    scan_y_next = (int'(scan_y_reg) == GRID_HEIGHT - 1) ? '0
                                                        : scan_y_reg + Y_W'(1);
                end
                else
                begin
                    scan_x_next = scan_x_reg + X_W'(1);
                end
                if (last_cell)
                begin
                    done_next  = 1'b1;
                    sweep_next = '0;
                    sl_raddr   = '0;
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_SWEEP:
            begin
                // close every active slot with no cell burning this generation
                sl_raddr = slot_inc(sweep_reg);
                sl_waddr = sweep_reg;
                sl_wdata = {1'b0, sl_rdata[SE_STAMP], sl_rdata[31:0]};
                if (sl_rdata[SE_ACTIVE] && (sl_rdata[SE_STAMP] != gen_reg))
                begin
                    sl_we = 1'b1;
                    if (sl_rdata[31:0] != '0)
                    begin
                        hist_we     = 1'b1;
                        closed_next = sat_inc32(closed_reg);
                        if (sl_rdata[31:0] > biggest_reg)
                        begin
                            biggest_next = sl_rdata[31:0];
                        end
                    end
                end
                sweep_next = sweep_reg + SLOT_W'(1);
                if (int'(sweep_reg) == FIRE_SLOTS - 1)
                begin
                    gen_next   = !gen_reg;
                    bsel_next  = !bsel_reg;
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_last_next         = done_reg;
                    out_data_next         = '0;
                    out_data_next[1:0]    = ns_reg;
                    out_data_next[12:2]   = burning_reg ? slot_reg : '0;
                    out_data_next[13]     = dropped_reg;
                    if (done_reg)
                    begin
                        out_data_next[30:14]  = tree_tally_reg;
                        out_data_next[47:31]  = burn_tally_reg;
                        out_data_next[79:48]  = closed_reg;
                        out_data_next[111:80] = biggest_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            bsel_reg       <= 1'b0;
            gen_reg        <= 1'b0;
            next_slot_reg  <= '0;
            scan_x_reg     <= '0;
            scan_y_reg     <= '0;
            tree_tally_reg <= '0;
            burn_tally_reg <= '0;
            closed_reg     <= '0;
            biggest_reg    <= '0;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            for (int b = 0; b < NUM_BINS; b++)
            begin
                hist_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            bsel_reg       <= bsel_next;
            gen_reg        <= gen_next;
            next_slot_reg  <= next_slot_next;
            scan_x_reg     <= scan_x_next;
            scan_y_reg     <= scan_y_next;
            tree_tally_reg <= tree_tally_next;
            burn_tally_reg <= burn_tally_next;
            closed_reg     <= closed_next;
            biggest_reg    <= biggest_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_valid_reg  <= out_valid_next;
            if (hist_we)
            begin
                hist_reg[hist_bin] <= sat_inc32(hist_reg[hist_bin]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rgrow_reg     <= rgrow_next;
        rstrike_reg   <= rstrike_next;
        k_reg         <= k_next;
        ns_reg        <= ns_next;
        slot_reg      <= slot_next;
        burning_reg   <= burning_next;
        dropped_reg   <= dropped_next;
        done_reg      <= done_next;
        probe_reg     <= probe_next;
        probe_cnt_reg <= probe_cnt_next;
        sweep_reg     <= sweep_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

[rtl/ffca_ram.sv]
`timescale 1ns / 1ps

module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[test/forest_fire_ca_step_tb.sv]
`timescale 1ns / 1ps

module forest_fire_ca_step_tb;
    import ffca_pkg::*;

    localparam int  RUN_LIMIT  = 4_000_000; // cycles
    localparam int  DRAIN_WAIT = FIRE_SLOTS + 64;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // expected contents of one result transaction
    typedef struct {
        logic [1:0]  new_state;
        logic [10:0] fire_slot;
        logic        dropped;
        logic        gen_done;
        logic [16:0] trees;
        logic [16:0] burning;
        logic [31:0] fires_total;
        logic [31:0] largest;
        logic [31:0] bin_count;
    } cell_result_t;

    // Scoreboard: keeps a private copy of the automaton, predicts the result
    // of every accepted input transaction and checks results in order.
    class fire_scoreboard;
        logic [1:0]  grid [0:1][0:CELL_COUNT-1];
        logic        cur_sel;
        logic [10:0] fire_of [0:CELL_COUNT-1];
        logic [31:0] slot_size [0:FIRE_SLOTS-1];
        logic [16:0] slot_alive [0:FIRE_SLOTS-1];
        bit          slot_busy [0:FIRE_SLOTS-1];
        int          next_slot;
        logic [31:0] hist [0:NUM_BINS-1];
        logic [31:0] closed_cnt;
        logic [31:0] biggest;
        int          scan;
        logic [16:0] tree_tally;
        logic [16:0] burn_tally;
        logic [31:0] grow_thr;
        logic [31:0] strike_thr;
        cell_result_t pending_cells[$];
        int          errors;

        function new();
            for (int i = 0; i < CELL_COUNT; i++)
            begin
                grid[0][i] = ST_EMPTY;
                grid[1][i] = ST_EMPTY;
                fire_of[i] = '0;
            end
            for (int f = 0; f < FIRE_SLOTS; f++)
            begin
                slot_size[f]  = '0;
                slot_alive[f] = '0;
                slot_busy[f]  = 1'b0;
            end
            for (int b = 0; b < NUM_BINS; b++)
                hist[b] = '0;
            cur_sel    = 1'b0;
            next_slot  = 0;
            closed_cnt = '0;
            biggest    = '0;
            scan       = 0;
            tree_tally = '0;
            burn_tally = '0;
            grow_thr   = GROW_THR_RESET;
            strike_thr = STRIKE_THR_RESET;
            errors     = 0;
        endfunction

        function void set_threshold(logic idx, logic [31:0] val);
            if (idx == CFG_GROW)
                grow_thr = val;
            else
                strike_thr = val;
        endfunction

        function logic [31:0] inc32(logic [31:0] v);
            return (v == U32_MAX) ? v : v + 32'd1;
        endfunction

        function logic [16:0] inc17(logic [16:0] v);
            return (v == TALLY_MAX) ? v : v + 17'd1;
        endfunction

        // round-robin search for a free fire slot
        function bit grab_slot(output int slot);
            int f;
            slot = 0;
            for (int k = 0; k < FIRE_SLOTS; k++)
            begin
                f = (next_slot + k) % FIRE_SLOTS;
                if (!slot_busy[f])
                begin
                    next_slot     = (f + 1) % FIRE_SLOTS;
                    slot_busy[f]  = 1'b1;
                    slot_size[f]  = '0;
                    slot_alive[f] = '0;
                    slot = f;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // end of generation: retire fires that no longer burn
        function void retire_cold_fires();
            int bin;
            logic [31:0] v;
            for (int f = 0; f < FIRE_SLOTS; f++)
            begin
                if (slot_busy[f] && slot_alive[f] == 0)
                begin
                    if (slot_size[f] != 0)
                    begin
                        bin = 0;
                        v = slot_size[f];
                        while (v > 1)
                        begin
                            v = v >> 1;
                            bin++;
                        end
                        if (bin >= NUM_BINS)
                            bin = NUM_BINS - 1;
                        hist[bin]  = inc32(hist[bin]);
                        closed_cnt = inc32(closed_cnt);
                        if (slot_size[f] > biggest)
                            biggest = slot_size[f];
                    end
                    slot_busy[f] = 1'b0;
                end
            end
        endfunction

        function void note_transaction(logic [1:0] md, logic [IN_DATA_W-1:0] d);
            cell_result_t r;
            int x, y, row, up, dn, xl, xr, slot, nb[4];
            logic [1:0] c, ns;
            bit burning, dropped;
            logic [15:0] cidx;
            logic [31:0] rgrow, rstrike;
            logic [4:0]  bidx;
            cidx    = d[15:0];
            rgrow   = d[48:17];
            rstrike = d[80:49];
            bidx    = d[85:81];
            r = '{default: '0};
            if (md == MODE_LOAD)
            begin
                if (cidx < CELL_COUNT)
                    grid[cur_sel][cidx] = {1'b0, d[16]};
            end
            else if (md == MODE_READ)
            begin
                if (bidx < NUM_BINS)
                    r.bin_count = hist[bidx];
            end
            else if (md == MODE_STEP)
            begin
                if (scan == 0)
                begin
                    for (int f = 0; f < FIRE_SLOTS; f++)
                        slot_alive[f] = '0;
                    tree_tally = '0;
                    burn_tally = '0;
                end
                x   = scan % GRID_WIDTH;
                y   = scan / GRID_WIDTH;
                row = y * GRID_WIDTH;
                xl  = (x == 0) ? GRID_WIDTH - 1 : x - 1;
                xr  = (x == GRID_WIDTH - 1) ? 0 : x + 1;
                up  = ((y == 0) ? GRID_HEIGHT - 1 : y - 1) * GRID_WIDTH;
                dn  = ((y == GRID_HEIGHT - 1) ? 0 : y + 1) * GRID_WIDTH;
                c   = grid[cur_sel][scan];
                burning = 1'b0;
                dropped = 1'b0;
                slot    = 0;
                ns      = ST_EMPTY;
                if (c == ST_FIRE)
                    ns = ST_EMPTY;
                else if (c == ST_TREE)
                begin
                    // neighbour order matters: first burning one wins
                    nb[0] = row + xl;
                    nb[1] = row + xr;
                    nb[2] = up + x;
                    nb[3] = dn + x;
                    for (int k = 0; k < 4; k++)
                    begin
                        if (!burning && grid[cur_sel][nb[k]] == ST_FIRE)
                        begin
                            slot    = int'(fire_of[nb[k]]);
                            burning = 1'b1;
                        end
                    end
                    if (!burning && rstrike < strike_thr)
                    begin
                        if (grab_slot(slot))
                            burning = 1'b1;
                        else
                            dropped = 1'b1;
                    end
                    if (burning)
                    begin
                        ns                = ST_FIRE;
                        fire_of[scan]     = slot[10:0];
                        slot_size[slot]   = inc32(slot_size[slot]);
                        slot_alive[slot]  = inc17(slot_alive[slot]);
                        burn_tally        = inc17(burn_tally);
                    end
                    else
                    begin
                        ns         = ST_TREE;
                        tree_tally = inc17(tree_tally);
                    end
                end
                else if (rgrow < grow_thr)
                begin
                    ns         = ST_TREE;
                    tree_tally = inc17(tree_tally);
                end
                grid[!cur_sel][scan] = ns;
                r.new_state = ns;
                r.fire_slot = burning ? slot[10:0] : '0;
                r.dropped   = dropped;
                if (scan == CELL_COUNT - 1)
                begin
                    scan    = 0;
                    cur_sel = !cur_sel;
                    retire_cold_fires();
                    r.gen_done    = 1'b1;
                    r.trees       = tree_tally;
                    r.burning     = burn_tally;
                    r.fires_total = closed_cnt;
                    r.largest     = biggest;
                end
                else
                    scan++;
            end
            pending_cells.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
            errors++;
        endtask

        task cmp(string what, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report(what, got, want);
        endtask

        task check_result(logic [OUT_DATA_W-1:0] d, logic last);
            cell_result_t e;
            if (pending_cells.size() == 0)
            begin
                report("unexpected result transaction", d[31:0], 32'd0);
                return;
            end
            e = pending_cells.pop_front();
            cmp("new_state", 32'(d[1:0]), 32'(e.new_state));
            cmp("fire_slot", 32'(d[12:2]), 32'(e.fire_slot));
            cmp("strike_dropped", 32'(d[13]), 32'(e.dropped));
            cmp("generation_done", 32'(last), 32'(e.gen_done));
            cmp("tree_count", 32'(d[30:14]), 32'(e.trees));
            cmp("burning_count", 32'(d[47:31]), 32'(e.burning));
            cmp("fires_total", d[79:48], e.fires_total);
            cmp("largest_fire", d[111:80], e.largest);
            cmp("bin_count", d[143:112], e.bin_count);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [31:0]           cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // [15:0] cell_index, [16] cell_value, [48:17] rand_grow,
    // [80:49] rand_strike, [85:81] bin_index, [87:86] zero
    logic [IN_DATA_W-1:0]  s_tdata;
    // [1:0] mode
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // [1:0] new_state, [12:2] fire_slot, [13] strike_dropped,
    // [30:14] tree_count, [47:31] burning_count, [79:48] fires_total,
    // [111:80] largest_fire, [143:112] bin_count
    logic [OUT_DATA_W-1:0] m_tdata;
    // generation_done
    logic                  m_tlast;

    fire_scoreboard sb;
    int send_idle_pct;   // percent of cycles the sender leaves a gap
    int recv_idle_pct;   // percent of cycles the receiver stalls
    int hold_off;        // pending long receiver stall, in cycles
    int cycles;

    forest_fire_ca_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Transaction monitor: both sides sampled at the edge, before the
    // design's nonblocking updates land, so ordering within a step is moot.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_transaction(s_tuser, s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    // Receiver: random stalls, plus an occasional long hold-off that lets
    // the block back up into its input side.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                hold_off = hold_off - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog; the post-reset clear pass is included in its count.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > RUN_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function logic [IN_DATA_W-1:0] pack_item(logic [15:0] cidx, logic cval,
                                             logic [31:0] rgrow, logic [31:0] rstrike,
                                             logic [4:0] bidx);
        return {2'b00, bidx, rstrike, rgrow, cval, cidx};
    endfunction

    // fully random payload
    function logic [IN_DATA_W-1:0] rand_item();
        return pack_item(16'($urandom), 1'($urandom), $urandom, $urandom,
                         5'($urandom));
    endfunction

    // Offer one transaction; returns on the edge that accepts it.
    task send(logic [1:0] md, logic [IN_DATA_W-1:0] d);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_cells.size() != 0)
            @(posedge clk);
    endtask

    // only called with no transaction in flight
    task write_cfg(logic idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_threshold(idx, val);
        @(posedge clk);
    endtask

    task step_cell();
        send(MODE_STEP, rand_item());
    endtask

    // Mostly steps, with loads (half of them landing just ahead of the scan so
    // that steps meet trees), and some reads and unused-mode transactions.
    task random_item();
        int sel;
        logic [15:0] idx;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            step_cell();
        else if (sel < 80)
        begin
            if ($urandom_range(0, 1))
                idx = 16'(sb.scan + int'($urandom_range(0, 300)));
            else
                idx = 16'($urandom);
            send(MODE_LOAD, pack_item(idx, 1'($urandom), $urandom, $urandom,
                                      5'($urandom)));
        end
        else if (sel < 95)
            send(MODE_READ, pack_item(16'($urandom), 1'($urandom), $urandom, $urandom,
                                      5'($urandom_range(0, 31))));
        else
            send(MODE_UNUSED, rand_item());
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off      = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_GROW;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_LOAD;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every threshold at its maximum so strikes and growth fire
        write_cfg(CFG_GROW, U32_MAX);
        write_cfg(CFG_STRIKE, U32_MAX);
        send(MODE_READ, pack_item('0, 1'b0, '0, '0, 5'd0));
        send(MODE_READ, pack_item('0, 1'b0, '0, '0, 5'd23));
        send(MODE_READ, pack_item('0, 1'b0, '0, '0, 5'd24));   // past last bin
        send(MODE_READ, pack_item('1, 1'b1, '1, '1, 5'd31));
        send(MODE_UNUSED, pack_item('1, 1'b1, '1, '1, 5'd31));
        send(MODE_LOAD, pack_item(16'hFFFF, 1'b1, '1, '1, '1));
        send(MODE_LOAD, pack_item(16'd0, 1'b1, '0, '0, '0));
        send(MODE_LOAD, pack_item(16'd1, 1'b1, '0, '0, '0));
        send(MODE_LOAD, pack_item(16'd256, 1'b1, '0, '0, '0));
        send(MODE_LOAD, pack_item(16'd4, 1'b1, '0, '0, '0));
        send(MODE_LOAD, pack_item(16'd4, 1'b0, '0, '0, '0));  // overwrite back to empty
        send(MODE_STEP, pack_item('0, 1'b0, '1, 32'd0, '0));  // tree struck, first slot
        send(MODE_STEP, pack_item('0, 1'b0, '0, '1, '0));     // draw at max: no strike
        send(MODE_STEP, pack_item('0, 1'b0, 32'd0, '0, '0));  // empty grows
        send(MODE_STEP, pack_item('0, 1'b0, '1, '0, '0));     // draw at max: no growth
        send(MODE_STEP, pack_item('0, 1'b0, '1, '0, '0));
        drain();

        // random: sender mostly busy, receiver mostly stalled, with one long
        // hold-off up front so the input side backs up
        write_cfg(CFG_GROW, GROW_THR_RESET);
        write_cfg(CFG_STRIKE, 32'h0100_0000);
        send_idle_pct = 11;
        recv_idle_pct = 86;
        hold_off      = 600;
        for (int n = 0; n < 150; n++)
            random_item();
        drain();

        write_cfg(CFG_GROW, 32'h8000_0000);
        write_cfg(CFG_STRIKE, 32'h0000_4000);
        send_idle_pct = 86;
        recv_idle_pct = 11;
        for (int n = 0; n < 150; n++)
            random_item();
        drain();

        write_cfg(CFG_STRIKE, STRIKE_THR_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 150; n++)
            random_item();
        for (int b = 0; b < 32; b++)
            send(MODE_READ, pack_item(16'($urandom), 1'($urandom), $urandom, $urandom,
                                      b[4:0]));
        drain();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0 && sb.pending_cells.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/ffca_pkg.sv
rtl/ffca_ram.sv
rtl/forest_fire_ca_step.sv
test/forest_fire_ca_step_tb.sv
